// ===== design/circle_overlap_area_top_assert.svh =====
// Assertion macros for the circle overlap area block.
// Used by circle_overlap_area_top; expects clk and arst_n in scope.
`ifndef CIRCLE_OVERLAP_AREA_TOP_ASSERT_SVH
`define CIRCLE_OVERLAP_AREA_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CAO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CAO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define CAO_ASSERT(lbl, prop, msg)
`define CAO_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== design/cao_pkg.sv =====
// Package for the circle overlap area block: word types, lane types, constants.
// Used by every module of the block; depends on nothing.
package cao_pkg;
	localparam int unsigned FRACTION_BITS_DEF = 16;
	localparam int unsigned DIV_STEPS = 30;
	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned CORDIC_STEPS = 30;
	localparam int unsigned AREA_W = 48;

	localparam logic [1:0] KIND_DISJOINT = 2'd0;
	localparam logic [1:0] KIND_INSIDE = 2'd1;
	localparam logic [1:0] KIND_LENS = 2'd2;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [62:0] ONE_Q60 = 63'h1000_0000_0000_0000;

	typedef struct packed {
		logic [31:0] center_distance;
		logic [31:0] radius_a;
		logic [31:0] radius_b;
	} cao_in_t;

	typedef struct packed {
		logic [47:0] overlap_area;
		logic [1:0]  overlap_kind;
	} cao_out_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] ra;
		logic [31:0] rb;
	} side_t;

	typedef struct packed {
		logic [65:0] rem;
		logic [64:0] den;
		logic [29:0] quo;
		logic        neg;
		logic        sat;
	} div_lane_t;

	typedef struct packed {
		logic [62:0] v;
		logic [62:0] r;
		logic [30:0] mag;
		logic        cneg;
	} sqrt_lane_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
		logic [30:0]        mag;
		logic [30:0]        s;
		logic               cneg;
	} cordic_lane_t;

	function automatic logic [30:0] cordic_angle(input int unsigned i);
		logic [30:0] a;
		unique case (i)
			0: a = 31'd843314857;
			1: a = 31'd497837830;
			2: a = 31'd263043837;
			3: a = 31'd133525159;
			4: a = 31'd67021687;
			5: a = 31'd33543516;
			6: a = 31'd16775851;
			7: a = 31'd8388437;
			8: a = 31'd4194283;
			9: a = 31'd2097149;
			default: a = 31'(1) << (30 - i);
		endcase
		return a;
	endfunction
endpackage

// ===== design/cao_div.sv =====
// Restoring divider pipeline, one quotient bit per stage, two lanes.
// Depends on cao_pkg.
module cao_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vin,
	input  cao_pkg::side_t            side_in,
	input  cao_pkg::div_lane_t [1:0]  lane_in,
	output logic                      vout,
	output cao_pkg::side_t            side_out,
	output cao_pkg::div_lane_t [1:0]  lane_out
);
	import cao_pkg::*;

	logic            vld_s  [DIV_STEPS];
	side_t           side_s [DIV_STEPS];
	div_lane_t [1:0] lane_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		div_lane_t [1:0] cur;
		div_lane_t [1:0] nxt;
		side_t           scur;
		logic            vcur;
		logic [65:0]     sh [2];

		if (k == 0) begin : g_first
			assign cur = lane_in;
			assign scur = side_in;
			assign vcur = vin;
		end else begin : g_next
			assign cur = lane_s[k-1];
			assign scur = side_s[k-1];
			assign vcur = vld_s[k-1];
		end

		always_comb begin
			nxt = cur;
			for (int l = 0; l < 2; l++) begin
				if (k == 0) begin
					nxt[l].sat = (cur[l].den == '0) || (cur[l].rem >= {1'b0, cur[l].den});
				end
				sh[l] = {cur[l].rem[64:0], 1'b0};
				if (sh[l] >= {1'b0, cur[l].den}) begin
					nxt[l].rem = sh[l] - {1'b0, cur[l].den};
					nxt[l].quo = {cur[l].quo[28:0], 1'b1};
				end else begin
					nxt[l].rem = sh[l];
					nxt[l].quo = {cur[l].quo[28:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vcur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[k] <= nxt;
				side_s[k] <= scur;
			end
		end
	end

	assign vout = vld_s[DIV_STEPS-1];
	assign side_out = side_s[DIV_STEPS-1];
	assign lane_out = lane_s[DIV_STEPS-1];
endmodule

// ===== design/cao_sqrt.sv =====
// Integer square root pipeline, one result bit per stage, two lanes.
// Depends on cao_pkg.
module cao_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vin,
	input  cao_pkg::side_t             side_in,
	input  cao_pkg::sqrt_lane_t [1:0]  lane_in,
	output logic                       vout,
	output cao_pkg::side_t             side_out,
	output cao_pkg::sqrt_lane_t [1:0]  lane_out
);
	import cao_pkg::*;

	logic             vld_s  [SQRT_STEPS];
	side_t            side_s [SQRT_STEPS];
	sqrt_lane_t [1:0] lane_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [62:0] STEP_BIT = 63'(1) << (62 - 2 * k);
		sqrt_lane_t [1:0] cur;
		sqrt_lane_t [1:0] nxt;
		side_t            scur;
		logic             vcur;
		logic [62:0]      trial [2];

		if (k == 0) begin : g_first
			assign cur = lane_in;
			assign scur = side_in;
			assign vcur = vin;
		end else begin : g_next
			assign cur = lane_s[k-1];
			assign scur = side_s[k-1];
			assign vcur = vld_s[k-1];
		end

		always_comb begin
			nxt = cur;
			for (int l = 0; l < 2; l++) begin
				trial[l] = cur[l].r + STEP_BIT;
				if (cur[l].v >= trial[l]) begin
					nxt[l].v = cur[l].v - trial[l];
					nxt[l].r = (cur[l].r >> 1) + STEP_BIT;
				end else begin
					nxt[l].r = cur[l].r >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vcur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[k] <= nxt;
				side_s[k] <= scur;
			end
		end
	end

	assign vout = vld_s[SQRT_STEPS-1];
	assign side_out = side_s[SQRT_STEPS-1];
	assign lane_out = lane_s[SQRT_STEPS-1];
endmodule

// ===== design/cao_cordic.sv =====
// Vectoring CORDIC pipeline for arccos, one rotation per stage, two lanes.
// Depends on cao_pkg (angle table).
module cao_cordic (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vin,
	input  cao_pkg::side_t               side_in,
	input  cao_pkg::cordic_lane_t [1:0]  lane_in,
	output logic                         vout,
	output cao_pkg::side_t               side_out,
	output cao_pkg::cordic_lane_t [1:0]  lane_out
);
	import cao_pkg::*;

	logic               vld_s  [CORDIC_STEPS];
	side_t              side_s [CORDIC_STEPS];
	cordic_lane_t [1:0] lane_s [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		localparam logic signed [32:0] STEP_ANG = {2'b00, cordic_angle(k)};
		cordic_lane_t [1:0] cur;
		cordic_lane_t [1:0] nxt;
		side_t              scur;
		logic               vcur;
		logic signed [33:0] dx [2];
		logic signed [33:0] dy [2];

		if (k == 0) begin : g_first
			assign cur = lane_in;
			assign scur = side_in;
			assign vcur = vin;
		end else begin : g_next
			assign cur = lane_s[k-1];
			assign scur = side_s[k-1];
			assign vcur = vld_s[k-1];
		end

		always_comb begin
			nxt = cur;
			for (int l = 0; l < 2; l++) begin
				dx[l] = cur[l].y >>> k;
				dy[l] = cur[l].x >>> k;
				if (!cur[l].y[33]) begin
					nxt[l].x = cur[l].x + dx[l];
					nxt[l].y = cur[l].y - dy[l];
					nxt[l].z = cur[l].z + STEP_ANG;
				end else begin
					nxt[l].x = cur[l].x - dx[l];
					nxt[l].y = cur[l].y + dy[l];
					nxt[l].z = cur[l].z - STEP_ANG;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vcur;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[k] <= nxt;
				side_s[k] <= scur;
			end
		end
	end

	assign vout = vld_s[CORDIC_STEPS-1];
	assign side_out = side_s[CORDIC_STEPS-1];
	assign lane_out = lane_s[CORDIC_STEPS-1];
endmodule

// ===== design/circle_overlap_area_top.sv =====
// Top level of the circle overlap area block: classify, divide, root, CORDIC, area.
// Depends on cao_pkg, cao_div, cao_sqrt, cao_cordic and the assertion header.
//
//  channel | signals                                  | word type
//  item    | item_valid, item_ready, item_word        | cao_in_t
//  result  | result_valid, result_ready, result_word  | cao_out_t
//
// One word enters per cycle while the pipeline advances; there are 4 front stages, 30 divider,
// 32 root, 30 CORDIC and 5 area stages.
// All stages advance together whenever the result register is empty or taken.
// Reset clears every valid bit; payload registers are not reset.
`include "circle_overlap_area_top_assert.svh"
module circle_overlap_area_top #(
	parameter int unsigned FRACTION_BITS = cao_pkg::FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  cao_pkg::cao_in_t  item_word,
	output logic              result_valid,
	input  logic              result_ready,
	output cao_pkg::cao_out_t result_word
);
	import cao_pkg::*;

	localparam int unsigned SHIFT = FRACTION_BITS + 30;

	logic adv;

	// stage 1: input register
	logic        vld_s1;
	logic [31:0] d_s1, ra_s1, rb_s1;

	// stage 2: products and class
	logic        vld_s2;
	logic [63:0] dd_s2, aa_s2, bb_s2, ad_s2, bd_s2;
	side_t       side_s2;
	logic [32:0] rsum;
	logic [31:0] mn, mx;
	logic [1:0]  kind;

	// stage 3: divider operands
	logic            vld_s3;
	side_t           side_s3;
	div_lane_t [1:0] lane_s3;
	logic [64:0]     pp [2];
	logic [63:0]     qq [2];
	logic [63:0]     rd [2];

	logic            div_v;
	side_t           div_side;
	div_lane_t [1:0] div_lane;

	// stage 4: root operand
	logic             vld_s4;
	side_t            side_s4;
	sqrt_lane_t [1:0] lane_s4;
	logic [30:0]      cmag [2];
	logic [61:0]      csq [2];

	logic             sq_v;
	side_t            sq_side;
	sqrt_lane_t [1:0] sq_lane;
	cordic_lane_t [1:0] cor_in;

	logic               cor_v;
	side_t              cor_side;
	cordic_lane_t [1:0] cor_lane;

	// stage 5: angle and c*s
	logic        vld_s5;
	logic [1:0]  kind_s5;
	logic [31:0] ang_s5 [2];
	logic [31:0] cs_s5 [2];
	logic        cneg_s5 [2];
	logic [63:0] r2_s5 [2];
	logic [31:0] zc [2];
	logic [61:0] csp [2];
	logic [31:0] rop;

	// stage 6: lens terms
	logic        vld_s6;
	logic [1:0]  kind_s6;
	logic [32:0] t_s6 [2];
	logic [63:0] r2_s6 [2];
	logic [32:0] tt [2];

	// stage 7: partial products
	logic        vld_s7;
	logic [1:0]  kind_s7;
	logic [64:0] plo_s7 [2];
	logic [64:0] phi_s7 [2];

	// stage 8: products
	logic        vld_s8;
	logic [1:0]  kind_s8;
	logic [96:0] prod_s8 [2];

	// stage 9: result register
	logic        vld_s9;
	cao_out_t    word_s9;
	logic [97:0] asum, ashift;

	assign adv = !vld_s9 || result_ready;
	assign item_ready = adv;
	assign result_valid = vld_s9;
	assign result_word = word_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= div_v;
			vld_s5 <= cor_v;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// stage 2 logic
	always_comb begin
		rsum = {1'b0, ra_s1} + {1'b0, rb_s1};
		mn = (ra_s1 < rb_s1) ? ra_s1 : rb_s1;
		mx = (ra_s1 < rb_s1) ? rb_s1 : ra_s1;
		if ({1'b0, d_s1} >= rsum) begin
			kind = KIND_DISJOINT;
		end else if (({1'b0, d_s1} + {1'b0, mn}) <= {1'b0, mx}) begin
			kind = KIND_INSIDE;
		end else begin
			kind = KIND_LENS;
		end
	end

	// stage 3 logic: lane 0 is circle a, lane 1 is circle b
	always_comb begin
		pp[0] = {1'b0, dd_s2} + {1'b0, aa_s2};
		qq[0] = bb_s2;
		rd[0] = ad_s2;
		pp[1] = {1'b0, dd_s2} + {1'b0, bb_s2};
		qq[1] = aa_s2;
		rd[1] = bd_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= item_word.center_distance;
			ra_s1 <= item_word.radius_a;
			rb_s1 <= item_word.radius_b;

			dd_s2 <= 64'(d_s1) * 64'(d_s1);
			aa_s2 <= 64'(ra_s1) * 64'(ra_s1);
			bb_s2 <= 64'(rb_s1) * 64'(rb_s1);
			ad_s2 <= 64'(ra_s1) * 64'(d_s1);
			bd_s2 <= 64'(rb_s1) * 64'(d_s1);
			side_s2 <= '{kind: kind, ra: ra_s1, rb: rb_s1};

			side_s3 <= side_s2;
			for (int l = 0; l < 2; l++) begin
				lane_s3[l].neg <= pp[l] < {1'b0, qq[l]};
				lane_s3[l].rem <= (pp[l] < {1'b0, qq[l]}) ?
					66'({1'b0, qq[l]} - pp[l]) : 66'(pp[l] - {1'b0, qq[l]});
				lane_s3[l].den <= {rd[l], 1'b0};
				lane_s3[l].quo <= '0;
				lane_s3[l].sat <= 1'b0;
			end
		end
	end

	cao_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vin      (vld_s3),
		.side_in  (side_s3),
		.lane_in  (lane_s3),
		.vout     (div_v),
		.side_out (div_side),
		.lane_out (div_lane)
	);

	// stage 4 logic: cosine magnitude, then 1 - c^2
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			cmag[l] = div_lane[l].sat ? ONE_Q30 : {1'b0, div_lane[l].quo};
			csq[l] = 62'(cmag[l]) * 62'(cmag[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= div_side;
			for (int l = 0; l < 2; l++) begin
				lane_s4[l].v <= ONE_Q60 - 63'(csq[l]);
				lane_s4[l].r <= '0;
				lane_s4[l].mag <= cmag[l];
				lane_s4[l].cneg <= div_lane[l].neg && (cmag[l] != '0);
			end
		end
	end

	cao_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vin      (vld_s4),
		.side_in  (side_s4),
		.lane_in  (lane_s4),
		.vout     (sq_v),
		.side_out (sq_side),
		.lane_out (sq_lane)
	);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			cor_in[l].x = {3'b000, sq_lane[l].mag};
			cor_in[l].y = {3'b000, sq_lane[l].r[30:0]};
			cor_in[l].z = '0;
			cor_in[l].mag = sq_lane[l].mag;
			cor_in[l].s = sq_lane[l].r[30:0];
			cor_in[l].cneg = sq_lane[l].cneg;
		end
	end

	cao_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vin      (sq_v),
		.side_in  (sq_side),
		.lane_in  (cor_in),
		.vout     (cor_v),
		.side_out (cor_side),
		.lane_out (cor_lane)
	);

	// stage 5 logic
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (cor_lane[l].z[32]) begin
				zc[l] = '0;
			end else if (cor_lane[l].z[31:0] > HALF_PI_Q30) begin
				zc[l] = HALF_PI_Q30;
			end else begin
				zc[l] = cor_lane[l].z[31:0];
			end
			csp[l] = 62'(cor_lane[l].mag) * 62'(cor_lane[l].s);
		end
		if (cor_side.kind == KIND_INSIDE) begin
			rop = (cor_side.ra < cor_side.rb) ? cor_side.ra : cor_side.rb;
		end else begin
			rop = cor_side.ra;
		end
	end

	// stage 6 logic
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (cneg_s5[l]) begin
				tt[l] = 33'(ang_s5[l]) + 33'(cs_s5[l]);
			end else if (ang_s5[l] >= cs_s5[l]) begin
				tt[l] = 33'(ang_s5[l] - cs_s5[l]);
			end else begin
				tt[l] = '0;
			end
		end
		if (kind_s5 == KIND_INSIDE) begin
			tt[0] = 33'(PI_Q30);
			tt[1] = '0;
		end
	end

	// stage 9 logic
	always_comb begin
		asum = 98'(prod_s8[0]) + 98'(prod_s8[1]);
		ashift = asum >> SHIFT;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s5 <= cor_side.kind;
			r2_s5[0] <= 64'(rop) * 64'(rop);
			r2_s5[1] <= 64'(cor_side.rb) * 64'(cor_side.rb);
			for (int l = 0; l < 2; l++) begin
				ang_s5[l] <= cor_lane[l].cneg ? (PI_Q30 - zc[l]) : zc[l];
				cs_s5[l] <= csp[l][61:30];
				cneg_s5[l] <= cor_lane[l].cneg;
			end

			kind_s6 <= kind_s5;
			for (int l = 0; l < 2; l++) begin
				t_s6[l] <= tt[l];
				r2_s6[l] <= r2_s5[l];
			end

			kind_s7 <= kind_s6;
			for (int l = 0; l < 2; l++) begin
				plo_s7[l] <= 65'(r2_s6[l][31:0]) * 65'(t_s6[l]);
				phi_s7[l] <= 65'(r2_s6[l][63:32]) * 65'(t_s6[l]);
			end

			kind_s8 <= kind_s7;
			for (int l = 0; l < 2; l++) begin
				prod_s8[l] <= {phi_s7[l], 32'b0} + 97'(plo_s7[l]);
			end

			word_s9.overlap_kind <= kind_s8;
			if (kind_s8 == KIND_DISJOINT) begin
				word_s9.overlap_area <= '0;
			end else if (ashift[97:AREA_W] != '0) begin
				word_s9.overlap_area <= '1;
			end else begin
				word_s9.overlap_area <= ashift[AREA_W-1:0];
			end
		end
	end

	`CAO_ASSERT_IMP(a_stall_blocks_input, vld_s9 && !result_ready, !item_ready, "word taken while result stalled")
	`CAO_ASSERT_IMP(a_disjoint_zero, vld_s9 && (word_s9.overlap_kind == KIND_DISJOINT), word_s9.overlap_area == '0, "disjoint word with nonzero area")
	`CAO_ASSERT(a_stall_holds, !adv |=> $stable(vld_s1) && $stable(vld_s5) && $stable(vld_s9), "pipeline advanced during stall")
endmodule

// ===== tb/sv/tb_circle_overlap_area_top.sv =====
// Testbench for circle_overlap_area_top: random and corner-case circle pairs, exact area check.
// Depends on cao_pkg and the block; a scoreboard class holds its own bit-exact area predictor.
`timescale 1ns / 100ps
module tb_circle_overlap_area_top;
	import cao_pkg::*;

	localparam int unsigned FRAC = 16;
	localparam int unsigned N_ITEMS = 950;
	localparam int unsigned CALM_ITEMS = 150;

	class overlap_scoreboard;
		cao_out_t expected_q[$];
		int unsigned mismatches = 0;
		int unsigned orphans = 0;

		function longint half_cos(logic [63:0] rn, logic [63:0] ro, logic [63:0] d);
			logic [129:0] p, q, den, rem;
			logic neg;
			longint quo;
			p = 130'(d) * 130'(d) + 130'(rn) * 130'(rn);
			q = 130'(ro) * 130'(ro);
			den = (130'(rn) * 130'(d)) << 1;
			neg = p < q;
			rem = neg ? q - p : p - q;
			quo = 0;
			if (den == 0)
				return 64'sd1 << 30;
			if (rem >= den)
				return neg ? -(64'sd1 << 30) : (64'sd1 << 30);
			for (int i = 0; i < 30; i++) begin
				rem = rem << 1;
				quo = quo << 1;
				if (rem >= den) begin
					rem = rem - den;
					quo = quo | 1;
				end
			end
			return neg ? -quo : quo;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function longint arc_cos(longint c, longint s);
			longint x, y, z, a, dx, dy;
			x = c < 0 ? -c : c;
			y = s;
			z = 0;
			for (int i = 0; i < 30; i++) begin
				a = (i < 10) ? longint'(cordic_angle(i)) : (64'sd1 << (30 - i));
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x = x + dx; y = y - dy; z = z + a;
				end else begin
					x = x - dx; y = y + dy; z = z - a;
				end
			end
			if (z < 0)
				z = 0;
			if (z > longint'(HALF_PI_Q30))
				z = longint'(HALF_PI_Q30);
			return c < 0 ? longint'(PI_Q30) - z : z;
		endfunction

		function longint unsigned segment_term(longint c);
			longint unsigned mag, s;
			longint ang, cs, t;
			mag = c < 0 ? -c : c;
			s = int_sqrt((64'd1 << 60) - mag * mag);
			ang = arc_cos(c, longint'(s));
			cs = longint'((mag * s) >> 30);
			t = ang - (c < 0 ? -cs : cs);
			return t < 0 ? 0 : longint'(t);
		endfunction

		function logic [47:0] shift_sat(logic [127:0] v);
			logic [127:0] r;
			r = v >> (FRAC + 30);
			return (r > 128'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF : r[47:0];
		endfunction

		function cao_out_t predict_overlap(cao_in_t w);
			cao_out_t o;
			logic [63:0] d, ra, rb, mn, mx, ta, tb;
			d = w.center_distance;
			ra = w.radius_a;
			rb = w.radius_b;
			mn = ra < rb ? ra : rb;
			mx = ra < rb ? rb : ra;
			if (d >= ra + rb) begin
				o.overlap_area = '0;
				o.overlap_kind = KIND_DISJOINT;
			end else if (d + mn <= mx) begin
				o.overlap_area = shift_sat(128'(mn * mn) * 128'(PI_Q30));
				o.overlap_kind = KIND_INSIDE;
			end else begin
				tb = segment_term(half_cos(rb, ra, d));
				ta = segment_term(half_cos(ra, rb, d));
				o.overlap_area = shift_sat(128'(rb * rb) * 128'(tb) + 128'(ra * ra) * 128'(ta));
				o.overlap_kind = KIND_LENS;
			end
			return o;
		endfunction

		function void note_item(cao_in_t w);
			expected_q.push_back(predict_overlap(w));
		endfunction

		function void check_result(cao_out_t got);
			cao_out_t exp_w;
			if (expected_q.size() == 0) begin
				orphans++;
				if (mismatches + orphans <= 10)
					$display("unexpected result word: area %0d kind %0d",
						got.overlap_area, got.overlap_kind);
				return;
			end
			exp_w = expected_q.pop_front();
			if (got.overlap_area !== exp_w.overlap_area || got.overlap_kind !== exp_w.overlap_kind)
			begin
				mismatches++;
				if (mismatches + orphans <= 10)
					$display("mismatch: expected area %0d kind %0d, got area %0d kind %0d",
						exp_w.overlap_area, exp_w.overlap_kind,
						got.overlap_area, got.overlap_kind);
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_ready;
	cao_in_t  item_word = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	cao_out_t result_word;

	overlap_scoreboard sb = new();
	bit calm = 1'b0;
	bit feed_done = 1'b0;
	cao_in_t plan_q[$];

	circle_overlap_area_top #(.FRACTION_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item_word(item_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_word(result_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			sb.note_item(item_word);
		if (arst_n && result_valid && result_ready)
			sb.check_result(result_word);
	end

	function automatic logic [31:0] rand_mag();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	function automatic cao_in_t make_word(logic [31:0] d, logic [31:0] a, logic [31:0] b);
		cao_in_t w;
		w.center_distance = d;
		w.radius_a = a;
		w.radius_b = b;
		return w;
	endfunction

	function automatic cao_in_t make_lens();
		logic [63:0] a, b, lo, hi, span, d;
		a = rand_mag();
		b = rand_mag();
		lo = a > b ? a - b : b - a;
		hi = a + b;
		if (hi - lo > 1) begin
			span = hi - lo - 1;
			d = lo + 1 + ({$urandom, $urandom} % span);
			if (d > 64'hFFFF_FFFF)
				d = lo + 1;
		end else begin
			d = lo;
		end
		return make_word(d[31:0], a[31:0], b[31:0]);
	endfunction

	task automatic build_plan();
		logic [31:0] m;
		m = 32'hFFFF_FFFF;
		plan_q.push_back(make_word(0, 0, 0));
		plan_q.push_back(make_word(m, m, m));
		plan_q.push_back(make_word(0, m, m));
		plan_q.push_back(make_word(0, m, 0));
		plan_q.push_back(make_word(0, 0, 32'h0001_0000));
		plan_q.push_back(make_word(m, 0, 0));
		plan_q.push_back(make_word(32'h0002_0000, 32'h0001_0000, 32'h0001_0000));
		plan_q.push_back(make_word(32'h0001_FFFF, 32'h0001_0000, 32'h0001_0000));
		plan_q.push_back(make_word(32'h0001_0000, 32'h0003_0000, 32'h0002_0000));
		plan_q.push_back(make_word(32'h0001_0001, 32'h0003_0000, 32'h0002_0000));
		plan_q.push_back(make_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		plan_q.push_back(make_word(32'h0000_8000, 32'h0001_0000, 32'h0001_0000));
		plan_q.push_back(make_word(1, 1, 1));
		plan_q.push_back(make_word(1, 1, 2));
		plan_q.push_back(make_word(32'h8000_0000, m, m));
		plan_q.push_back(make_word(32'h1000_0000, m, 32'h1000_0000));
		plan_q.push_back(make_word(m - 1, m, 1));
		plan_q.push_back(make_word(32'h0003_0000, 32'h0002_0000, 32'h0002_0000));
		plan_q.push_back(make_word(32'h0000_0001, 32'h0005_0000, 32'h0005_0000));
		plan_q.push_back(make_word(32'h7FFF_FFFF, 32'h4000_0000, 32'h4000_0000));
		while (plan_q.size() < N_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1: plan_q.push_back(make_word($urandom, $urandom, $urandom));
				2: plan_q.push_back(make_word(rand_mag(), rand_mag(), rand_mag()));
				default: plan_q.push_back(make_lens());
			endcase
		end
	endtask

	initial begin
		int unsigned gap;
		build_plan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < plan_q.size(); n++) begin
			calm = (n >= plan_q.size() - CALM_ITEMS);
			if (!calm && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 15);
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			item_valid <= 1'b1;
			item_word <= plan_q[n];
			do
				@(posedge clk);
			while (!(item_valid && item_ready));
		end
		item_valid <= 1'b0;
		feed_done = 1'b1;
	end

	initial begin
		int unsigned stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				result_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 15) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (feed_done);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (sb.mismatches == 0 && sb.orphans == 0 && sb.expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end
endmodule

// ===== circle_overlap_area_top.f =====
+incdir+design
design/cao_pkg.sv
design/cao_div.sv
design/cao_sqrt.sv
design/cao_cordic.sv
design/circle_overlap_area_top.sv
tb/sv/tb_circle_overlap_area_top.sv
